### src/fste_pkg.sv
// ----------------------------------------------------------------------------
// Flow shop tardiness evaluator package
// Shared widths, limits and payload types for the machine chain and its tail.
// ----------------------------------------------------------------------------
`default_nettype none

package fste_pkg;

   localparam int MACHINES_DEFAULT = 5;
   localparam int PROC_FIELDS      = 5;
   localparam int TAG_W            = 16;
   localparam int PROC_W           = 16;
   localparam int DUE_W            = 32;
   localparam int TIME_W           = 40;
   localparam int SUM_W            = 48;
   localparam int DIFF_W           = TIME_W + 2;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
   localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

   typedef struct packed {
      logic                     first_job;
      logic                     last_job;
      logic [TAG_W-1:0]         job_tag;
      logic [PROC_W-1:0]        setup_len;
      logic [PROC_W-1:0]        proc_time_m0;
      logic [PROC_W-1:0]        proc_time_m1;
      logic [PROC_W-1:0]        proc_time_m2;
      logic [PROC_W-1:0]        proc_time_m3;
      logic [PROC_W-1:0]        proc_time_m4;
      logic signed [DUE_W-1:0]  due_date;
   } req_type;

   typedef struct packed {
      logic [TAG_W-1:0]  tag_out;
      logic [TIME_W-1:0] finish_time;
      logic [TIME_W-1:0] job_tardiness;
      logic [SUM_W-1:0]  tard_total;
      logic              end_of_schedule;
      logic              overflow;
   } rsp_type;

   // Job as it travels along the chain of machine cells.
   typedef struct packed {
      logic                               first;
      logic                               last;
      logic [TAG_W-1:0]                   tag;
      logic [PROC_W-1:0]                  setup;
      logic signed [DUE_W-1:0]            due;
      logic [PROC_FIELDS-1:0][PROC_W-1:0] proc;
   } job_type;

   // What one cell hands to its right-hand neighbour.
   typedef struct packed {
      job_type           job;
      logic [TIME_W-1:0] avail;
      logic              ovf;
   } stage_type;

endpackage

`default_nettype wire

### src/fste_cell.sv
// ----------------------------------------------------------------------------
// Flow shop machine cell
// Holds one machine's last completion time and computes the job's completion.
// ----------------------------------------------------------------------------
`default_nettype none

module fste_cell #(
   parameter int CELL_INDEX = 0
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire logic                in_valid,
   input  wire fste_pkg::stage_type in_stage,
   output logic                     out_valid,
   output fste_pkg::stage_type      out_stage
);
   import fste_pkg::*;

   logic [PROC_W-1:0] proc;
   logic [PROC_W-1:0] setup_eff;
   logic [TIME_W-1:0] base;
   logic [TIME_W:0]   ready_sum;
   logic [TIME_W-1:0] ready;
   logic [TIME_W-1:0] start;
   logic [TIME_W:0]   fin_sum;
   logic [TIME_W-1:0] fin;
   logic              sticky_in;

   logic              valid_ff;
   stage_type         stage_ff;
   logic [TIME_W-1:0] finish_ff;
   logic              sticky_ff;

   // Machines beyond the input fields process for zero time.
   generate
      if (CELL_INDEX < PROC_FIELDS) begin : g_proc
         assign proc = in_stage.job.proc[CELL_INDEX];
      end else begin : g_no_proc
         assign proc = '0;
      end
   endgenerate

   always_comb begin
      setup_eff = in_stage.job.first ? '0 : in_stage.job.setup;
      base      = in_stage.job.first ? '0 : finish_ff;
      ready_sum = {1'b0, base} + {{(TIME_W + 1 - PROC_W){1'b0}}, setup_eff};
      ready     = ready_sum[TIME_W] ? TIME_MAX : ready_sum[TIME_W-1:0];
      start     = (ready > in_stage.avail) ? ready : in_stage.avail;
      fin_sum   = {1'b0, start} + {{(TIME_W + 1 - PROC_W){1'b0}}, proc};
      fin       = fin_sum[TIME_W] ? TIME_MAX : fin_sum[TIME_W-1:0];
      sticky_in = (in_stage.job.first ? 1'b0 : sticky_ff) | ready_sum[TIME_W]
                  | fin_sum[TIME_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         finish_ff <= '0;
         sticky_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
         if (in_valid) begin
            finish_ff <= fin;
            sticky_ff <= sticky_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         stage_ff.job   <= in_stage.job;
         stage_ff.avail <= fin;
         stage_ff.ovf   <= in_stage.ovf | sticky_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

`default_nettype wire

### src/fste_tail.sv
// ----------------------------------------------------------------------------
// Flow shop tardiness tail
// Two stages: the job's tardiness, then the running tardiness total.
// ----------------------------------------------------------------------------
`default_nettype none

module fste_tail (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire logic                in_valid,
   input  wire fste_pkg::stage_type in_stage,
   output logic                     out_valid,
   output fste_pkg::rsp_type        out_rsp
);
   import fste_pkg::*;

   logic signed [DIFF_W-1:0] diff;
   logic                     diff_pos;
   logic                     tard_clip;
   logic [TIME_W-1:0]        tard;
   logic                     tard_sticky_in;
   logic [SUM_W:0]           sum_full;
   logic [SUM_W-1:0]         sum_next;
   logic                     sum_sticky_in;

   // Tardiness stage.
   logic              a_valid_ff;
   logic              a_first_ff;
   logic              a_last_ff;
   logic [TAG_W-1:0]  a_tag_ff;
   logic [TIME_W-1:0] a_finish_ff;
   logic [TIME_W-1:0] a_tard_ff;
   logic              a_ovf_ff;
   logic              tard_sticky_ff;

   // Accumulator stage.
   logic              b_valid_ff;
   rsp_type           b_rsp_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic              sum_sticky_ff;

   always_comb begin
      diff = $signed({2'b00, in_stage.avail})
             - $signed({{(DIFF_W - DUE_W){in_stage.job.due[DUE_W-1]}},
                        in_stage.job.due});
      diff_pos       = !diff[DIFF_W-1] && (diff != '0);
      tard_clip      = diff_pos && diff[TIME_W];
      tard           = !diff_pos ? '0 : (tard_clip ? TIME_MAX : diff[TIME_W-1:0]);
      tard_sticky_in = (in_stage.job.first ? 1'b0 : tard_sticky_ff) | tard_clip;
   end

   always_comb begin
      sum_full      = {1'b0, (a_first_ff ? {SUM_W{1'b0}} : sum_ff)}
                      + {{(SUM_W + 1 - TIME_W){1'b0}}, a_tard_ff};
      sum_next      = sum_full[SUM_W] ? SUM_MAX : sum_full[SUM_W-1:0];
      sum_sticky_in = (a_first_ff ? 1'b0 : sum_sticky_ff) | sum_full[SUM_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff     <= 1'b0;
         tard_sticky_ff <= 1'b0;
         b_valid_ff     <= 1'b0;
         sum_ff         <= '0;
         sum_sticky_ff  <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         if (in_valid) begin
            tard_sticky_ff <= tard_sticky_in;
         end
         if (a_valid_ff) begin
            sum_ff        <= sum_next;
            sum_sticky_ff <= sum_sticky_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         a_first_ff  <= in_stage.job.first;
         a_last_ff   <= in_stage.job.last;
         a_tag_ff    <= in_stage.job.tag;
         a_finish_ff <= in_stage.avail;
         a_tard_ff   <= tard;
         a_ovf_ff    <= in_stage.ovf | tard_sticky_in;
      end
      if (advance && a_valid_ff) begin
         b_rsp_ff.tag_out         <= a_tag_ff;
         b_rsp_ff.finish_time     <= a_finish_ff;
         b_rsp_ff.job_tardiness   <= a_tard_ff;
         b_rsp_ff.tard_total      <= sum_next;
         b_rsp_ff.end_of_schedule <= a_last_ff;
         b_rsp_ff.overflow        <= a_ovf_ff | sum_sticky_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_rsp   = b_rsp_ff;

endmodule

`default_nettype wire

### src/flow_shop_tardiness_eval.sv
// ----------------------------------------------------------------------------
// Flow shop tardiness evaluator
// Systolic row of machine cells scoring a permutation schedule job by job.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Carries
//   req_     in         req_valid / req_ready  one job of the schedule
//   rsp_     out        rsp_valid / rsp_ready  completion, tardiness, total
//
// One job is taken per clock cycle while the skid entry is empty. A job
// passes MACHINES + 3 register stages (one per machine cell, two in the
// tardiness tail, one at the output): the cell row, then the tardiness and
// accumulator registers of the tail, then the output register. The rate is
// set by the cell row, in which every cell needs only its own previous
// completion and its neighbour's.
// Reset is synchronous and clears all machine completion times, the total
// and the overflow flags. A stalled result is parked in a one-entry skid
// register, so the input keeps taking transactions until that entry fills.
`default_nettype none

module flow_shop_tardiness_eval #(
   parameter int MACHINES = fste_pkg::MACHINES_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire fste_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output fste_pkg::rsp_type      rsp_data
);
   import fste_pkg::*;

   // The whole row moves together; it halts only while the skid entry is
   // occupied, which breaks any combinational path from rsp_ready to
   // req_ready.
   logic                advance;
   logic [MACHINES:0]   chain_valid;
   stage_type           chain_stage [0:MACHINES];
   stage_type           head_stage;
   logic                tail_valid;
   rsp_type             tail_rsp;

   logic                rsp_valid_ff;
   rsp_type             rsp_ff;
   logic                skid_valid_ff;
   rsp_type             skid_ff;

   assign advance   = !skid_valid_ff;
   assign req_ready = advance;

   // Feed of the first cell: the job as received, with no machine ahead of
   // machine 0, so its availability is zero.
   always_comb begin
      head_stage.job.first    = req_data.first_job;
      head_stage.job.last     = req_data.last_job;
      head_stage.job.tag      = req_data.job_tag;
      head_stage.job.setup    = req_data.setup_len;
      head_stage.job.due      = req_data.due_date;
      head_stage.job.proc[0]  = req_data.proc_time_m0;
      head_stage.job.proc[1]  = req_data.proc_time_m1;
      head_stage.job.proc[2]  = req_data.proc_time_m2;
      head_stage.job.proc[3]  = req_data.proc_time_m3;
      head_stage.job.proc[4]  = req_data.proc_time_m4;
      head_stage.avail        = '0;
      head_stage.ovf          = 1'b0;
   end

   assign chain_valid[0] = req_valid;
   assign chain_stage[0] = head_stage;

   // One cell per machine. Jobs pass each cell in schedule order, so every
   // cell sees the previous job's completion on its own machine.
   generate
      for (genvar m = 0; m < MACHINES; m++) begin : g_cell
         fste_cell #(
            .CELL_INDEX (m)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .advance   (advance),
            .in_valid  (chain_valid[m]),
            .in_stage  (chain_stage[m]),
            .out_valid (chain_valid[m+1]),
            .out_stage (chain_stage[m+1])
         );
      end
   endgenerate

   // Tardiness against the due date, then the running total.
   fste_tail u_tail (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (chain_valid[MACHINES]),
      .in_stage  (chain_stage[MACHINES]),
      .out_valid (tail_valid),
      .out_rsp   (tail_rsp)
   );

   // Output register with a skid entry. When the row advances, the tail's
   // result leaves the tail and must go either to the output register (if
   // that is free or being taken) or into the skid entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (advance) begin
         if (tail_valid) begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end else if (rsp_ready) begin
         skid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (tail_valid) begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_ff <= tail_rsp;
            end else begin
               skid_ff <= tail_rsp;
            end
         end
      end else if (rsp_ready) begin
         rsp_ff <= skid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The skid entry is only ever filled behind a waiting result.
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry occupied while the output register is empty");

   // A parked result is not dropped while the output stays stalled.
   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_ready |=> skid_valid_ff && rsp_valid_ff)
      else $error("parked result lost during an output stall");

   // Without saturation the running total includes this job's tardiness.
   a_total_covers_job: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.overflow |->
         rsp_ff.tard_total >= {{(SUM_W - TIME_W){1'b0}}, rsp_ff.job_tardiness})
      else $error("running total below the job tardiness without overflow");

endmodule

`default_nettype wire

### tb/sv/tardiness_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow shop tardiness checker
// Watches both channels of the evaluator, scores every accepted job with its
// own copy of the machine completion times and the running total, and
// compares each result transaction against the oldest outstanding score.
// ----------------------------------------------------------------------------
module tardiness_checker #(
   parameter int MACHINES = fste_pkg::MACHINES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  fste_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  fste_pkg::rsp_type rsp_data,
   output int                score_errors,
   output int                scores_due
);
   import fste_pkg::*;

   logic [TIME_W-1:0] machine_finish [MACHINES];
   logic [SUM_W-1:0]  tardiness_sum;
   logic              overflow_seen;

   rsp_type pending_scores [$];
   int      error_total;

   initial begin
      error_total  = 0;
   end

   function automatic void clear_schedule();
      int m;
      for (m = 0; m < MACHINES; m++) machine_finish[m] = '0;
      tardiness_sum = '0;
      overflow_seen = 1'b0;
   endfunction

   // Saturating sum; any clip marks the schedule as overflowed.
   function automatic logic [63:0] clip_add(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] limit);
      logic [63:0] s;
      s = a + b;
      if (s > limit) begin
         overflow_seen = 1'b1;
         return limit;
      end
      return s;
   endfunction

   function automatic rsp_type score_job(input req_type job);
      logic [63:0]    setup, avail, ready_at, start, proc, tard, due_ext;
      longint         lateness;
      int             m;
      rsp_type        score;
      if (job.first_job) begin
         clear_schedule();
         setup = '0;
      end else begin
         setup = 64'(job.setup_len);
      end
      avail = '0;
      for (m = 0; m < MACHINES; m++) begin
         case (m)
            0:       proc = 64'(job.proc_time_m0);
            1:       proc = 64'(job.proc_time_m1);
            2:       proc = 64'(job.proc_time_m2);
            3:       proc = 64'(job.proc_time_m3);
            4:       proc = 64'(job.proc_time_m4);
            default: proc = '0;
         endcase
         ready_at = clip_add(64'(machine_finish[m]), setup, 64'(TIME_MAX));
         start    = (ready_at > avail) ? ready_at : avail;
         machine_finish[m] = TIME_W'(clip_add(start, proc, 64'(TIME_MAX)));
         avail    = 64'(machine_finish[m]);
      end
      due_ext  = {{32{job.due_date[DUE_W-1]}}, job.due_date};
      lateness = longint'(avail) - longint'(due_ext);
      tard     = '0;
      if (lateness > 0) begin
         if (lateness > longint'(TIME_MAX)) begin
            overflow_seen = 1'b1;
            tard = 64'(TIME_MAX);
         end else begin
            tard = 64'(lateness);
         end
      end
      tardiness_sum = SUM_W'(clip_add(64'(tardiness_sum), tard, 64'(SUM_MAX)));
      score.tag_out         = job.job_tag;
      score.finish_time     = avail[TIME_W-1:0];
      score.job_tardiness   = tard[TIME_W-1:0];
      score.tard_total      = tardiness_sum;
      score.end_of_schedule = job.last_job;
      score.overflow        = overflow_seen;
      return score;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_schedule();
         pending_scores.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_scores.size() == 0) begin
               error_total++;
               if (error_total <= 10)
                  $display("unexpected result transaction: tag %h finish %h", rsp_data.tag_out,
                           rsp_data.finish_time);
            end else begin
               want = pending_scores.pop_front();
               if (rsp_data.tag_out !== want.tag_out ||
                   rsp_data.finish_time !== want.finish_time ||
                   rsp_data.job_tardiness !== want.job_tardiness ||
                   rsp_data.tard_total !== want.tard_total ||
                   rsp_data.end_of_schedule !== want.end_of_schedule ||
                   rsp_data.overflow !== want.overflow) begin
                  error_total++;
                  if (error_total <= 10)
                     $display({"mismatch (expected/actual): tag %h/%h finish %h/%h ",
                               "tardiness %h/%h total %h/%h end %b/%b overflow %b/%b"},
                              want.tag_out, rsp_data.tag_out,
                              want.finish_time, rsp_data.finish_time,
                              want.job_tardiness, rsp_data.job_tardiness,
                              want.tard_total, rsp_data.tard_total,
                              want.end_of_schedule, rsp_data.end_of_schedule,
                              want.overflow, rsp_data.overflow);
               end
            end
         end
         if (req_valid && req_ready)
            pending_scores.insert(pending_scores.size(), score_job(req_data));
      end
      score_errors <= error_total;
      scores_due   <= pending_scores.size();
   end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow shop tardiness evaluator testbench
// Drives directed and random job schedules into the evaluator under bursty
// input and a stalling result channel; the checker scores and compares.
// ----------------------------------------------------------------------------
module testbench;
   import fste_pkg::*;

   localparam int MACHINES = MACHINES_DEFAULT;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int score_errors;
   int scores_due;

   // Jobs accepted so far, and how many more go out before the sender rests.
   int jobs_sent;
   int burst_left;

   flow_shop_tardiness_eval #(
      .MACHINES(MACHINES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   tardiness_checker #(
      .MACHINES(MACHINES)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .score_errors(score_errors),
      .scores_due  (scores_due)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // A hard stop well beyond the slowest legitimate run.
   initial begin
      #500000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic req_type make_job(input logic first, input logic last,
                                        input logic [15:0] tag, input logic [15:0] setup,
                                        input logic [15:0] p0, input logic [15:0] p1,
                                        input logic [15:0] p2, input logic [15:0] p3,
                                        input logic [15:0] p4, input logic [31:0] due);
      req_type job;
      job.first_job    = first;
      job.last_job     = last;
      job.job_tag      = tag;
      job.setup_len    = setup;
      job.proc_time_m0 = p0;
      job.proc_time_m1 = p1;
      job.proc_time_m2 = p2;
      job.proc_time_m3 = p3;
      job.proc_time_m4 = p4;
      job.due_date     = due;
      return job;
   endfunction

   // Times lean towards zero, full scale and small values, with plenty of
   // uniformly random ones so that every bit toggles.
   function automatic logic [15:0] pick_duration();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2, 3, 4: return 16'($urandom_range(0, 50));
         default: return 16'($urandom);
      endcase
   endfunction

   // Due dates are spread so that some jobs are early, some exactly on the
   // edge of lateness and some very late, plus both signed extremes.
   function automatic logic [31:0] pick_due();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return $urandom;
         3:       return -32'($urandom_range(0, 1000));
         4, 5, 6: return 32'($urandom_range(0, 400000));
         7, 8:    return 32'($urandom_range(0, 4000000));
         default: return 32'h0000_0000;
      endcase
   endfunction

   // Most gaps are absent or short; now and then a long one lets the cell
   // row drain completely.
   function automatic int pick_gap();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return 0;
         5, 6, 7:       return $urandom_range(1, 3);
         8:             return $urandom_range(4, 8);
         default:       return $urandom_range(10, 20);
      endcase
   endfunction

   // Offers one job and holds it until the transaction completes. At the end
   // of a burst valid drops for the gap; with no gap it stays high so the next
   // job follows back to back.
   task automatic offer_job(input req_type job);
      int gap;
      req_data  <= job;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      jobs_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         gap = pick_gap();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
   endtask

   // The checker's outstanding count is registered, so the task waits on the
   // clock before it first looks at it.
   task automatic wait_for_scores();
      do @(posedge clock); while (scores_due != 0);
   endtask

   // Result side: a pattern of its own, mixing long ready stretches, short and
   // medium stalls and cycle-by-cycle dithering. Once, early in the random
   // part, it holds off long enough for the cell row and the skid entry to
   // fill, so that the input has to stall.
   initial begin
      int  span;
      int  pick;
      bit  hold_done;
      hold_done = 1'b0;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!hold_done && jobs_sent >= 150) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (120) @(posedge clock);
         end else begin
            pick = $urandom_range(0, 7);
            span = $urandom_range(1, 10);
            case (pick)
               0, 1, 2: begin
                  rsp_ready <= 1'b1;
                  repeat ($urandom_range(1, 30)) @(posedge clock);
               end
               3, 4: begin
                  rsp_ready <= 1'b0;
                  repeat ($urandom_range(1, 4)) @(posedge clock);
               end
               5: begin
                  rsp_ready <= 1'b0;
                  repeat ($urandom_range(5, 15)) @(posedge clock);
               end
               default: begin
                  repeat (span) begin
                     rsp_ready <= 1'($urandom_range(0, 1));
                     @(posedge clock);
                  end
               end
            endcase
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      req_type job;
      int      len;
      int      shape;
      int      k;
      int      random_sent;
      int      drain;
      bit      paused;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      jobs_sent   = 0;
      burst_left  = 6;
      random_sent = 0;
      paused      = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The very first job carries no first-job flag, so the
      // zero state after reset is used and its setup time counts.
      offer_job(make_job(1'b0, 1'b0, 16'h0000, 16'd100, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5,
                         32'h0000_0000));
      // Full-scale times, last job of the schedule, most negative due date.
      offer_job(make_job(1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFF, 16'hFFFF, 32'h8000_0000));
      // A job after the last one without a first-job flag carries the state on.
      offer_job(make_job(1'b0, 1'b0, 16'h0001, 16'd7, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                         32'h7FFF_FFFF));
      // First job: state cleared and its full-scale setup must be ignored.
      offer_job(make_job(1'b1, 1'b0, 16'h0002, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF));
      offer_job(make_job(1'b0, 1'b0, 16'h0003, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF,
                         32'h0000_0000));
      // Setup only, due date of minus one.
      offer_job(make_job(1'b0, 1'b0, 16'h0004, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                         32'hFFFF_FFFF));
      // The upstream machine dominates the own completion plus setup.
      offer_job(make_job(1'b0, 1'b1, 16'h0005, 16'd1, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0,
                         32'd300000));
      // Single-job schedules with zero work: on time, then one unit late.
      offer_job(make_job(1'b1, 1'b1, 16'h0006, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                         32'h0000_0000));
      offer_job(make_job(1'b1, 1'b1, 16'h0007, 16'hFF00, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                         32'hFFFF_FFFF));
      // Alternating bit patterns on every field.
      offer_job(make_job(1'b1, 1'b0, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'h5555,
                         16'hAAAA, 16'h5555, 32'h5555_5555));
      offer_job(make_job(1'b0, 1'b0, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'hAAAA,
                         16'h5555, 16'hAAAA, 32'hAAAA_AAAA));
      // Completion exactly on the due date, for both jobs of the schedule.
      offer_job(make_job(1'b1, 1'b0, 16'h0008, 16'd0, 16'd10, 16'd10, 16'd10, 16'd10,
                         16'd10, 32'd50));
      offer_job(make_job(1'b0, 1'b1, 16'h0009, 16'd0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1,
                         32'd51));
      // A short schedule with heavy setups building up the total.
      for (k = 0; k < 6; k++)
         offer_job(make_job(k == 0, k == 5, 16'(16'h0100 + k), 16'hFFFF - 16'(k), 16'h8000,
                            16'h0001, 16'hFFFF, 16'h0000, 16'h7FFF, -32'(k * 1000)));
      if (burst_left != 0) req_valid <= 1'b0;
      wait_for_scores();

      // Random part: mostly well-formed schedules with random content, the
      // rest with dropped first flags or scattered first and last flags.
      while (random_sent < 550) begin
         if ($urandom_range(0, 7) == 0) len = $urandom_range(13, 40);
         else len = $urandom_range(1, 12);
         shape = $urandom_range(0, 9);
         for (k = 0; k < len; k++) begin
            job.first_job = (k == 0);
            job.last_job  = (k == len - 1);
            if (shape == 0) begin
               job.first_job = 1'($urandom_range(0, 1));
               job.last_job  = 1'($urandom_range(0, 1));
            end else if (shape == 1) begin
               job.first_job = 1'b0;
            end
            job.job_tag      = 16'($urandom);
            job.setup_len    = pick_duration();
            job.proc_time_m0 = pick_duration();
            job.proc_time_m1 = pick_duration();
            job.proc_time_m2 = pick_duration();
            job.proc_time_m3 = pick_duration();
            job.proc_time_m4 = pick_duration();
            job.due_date     = pick_due();
            offer_job(job);
         end
         random_sent += len;
         // Once, rest at a schedule boundary until every result is back.
         if (!paused && jobs_sent >= 350) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            wait_for_scores();
         end
      end
      req_valid <= 1'b0;

      // Drain, with a bound so that a lost result ends as a leftover score.
      drain = 0;
      repeat (2) @(posedge clock);
      while (scores_due != 0 && drain < 4000) begin
         @(posedge clock);
         drain++;
      end
      repeat (MACHINES + 8) @(posedge clock);
      if (score_errors == 0 && scores_due == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
